// ===== rtl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// Used by spq_cell, sorted_priority_queue_unit and spq_checker; no dependencies.
package spq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int PRIO_W       = 16;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    localparam logic signed [VALUE_W-1:0] NO_VALUE = '1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Contents of one slot of the chain.
    typedef struct packed {
        logic                      vld;
        logic signed [PRIO_W-1:0]  prio;
        logic signed [VALUE_W-1:0] value;
    } t_entry;

    // Command broadcast to every cell in the cycle an item is taken.
    typedef struct packed {
        logic                      ins;
        logic                      rem;
        logic signed [PRIO_W-1:0]  prio;
        logic signed [VALUE_W-1:0] value;
    } t_ctl;

endpackage

// ===== rtl/sorted_priority_queue_unit.sv =====
// Top level of the sorted priority queue: a chain of spq_cell slots plus the
// command decode and registered result. Depends on spq_pkg and spq_cell.
//
// Usage:
//   Command channel: drive start high with i_action, i_item_value and
//   i_item_priority; the item is taken at a rising edge where start is high
//   and busy is low. Insert is action 0, remove is action 1.
//   Result channel: exactly one result per item. o_strobe is high for one
//   cycle, the cycle right after the item is taken, with o_removed_value and
//   o_status valid in that cycle. The receiver cannot stall it.
//   Throughput: one item every cycle once busy is low; busy drops when
//   the registered run flag is set after reset is released and stays low
//   from then on. The whole chain compares the incoming priority in
//   parallel and every slot shifts in the same edge, so no item waits.
//   Insert: the pair lands behind all entries of equal or higher priority,
//   except that a priority at or above the front's goes to the front.
//   Insert on a full queue drops the pair and reports full; remove on an
//   empty queue reports empty. Both return all ones as the value.
//   Reset (i_rst_n low, synchronous) empties the queue and holds busy high.
module sorted_priority_queue_unit #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_action,
    input  logic signed [spq_pkg::VALUE_W-1:0] i_item_value,
    input  logic signed [spq_pkg::PRIO_W-1:0]  i_item_priority,
    output logic                               o_strobe,
    output logic signed [spq_pkg::VALUE_W-1:0] o_removed_value,
    output logic [1:0]                         o_status
);

    spq_pkg::t_entry w_ent    [CAPACITY];
    logic            w_placed [CAPACITY+1];
    spq_pkg::t_ctl   w_ctl;

    logic w_take;
    logic w_full;
    logic w_empty;

    logic                               r_run;
    logic                               r_strobe;
    logic signed [spq_pkg::VALUE_W-1:0] r_value;
    spq_pkg::t_status                   r_status;
    logic signed [spq_pkg::VALUE_W-1:0] n_value;
    spq_pkg::t_status                   n_status;

    // The chain is kept packed at the front, so the tail slot marks full
    // and the head slot marks empty.
    assign w_full  = w_ent[CAPACITY-1].vld;
    assign w_empty = !w_ent[0].vld;
    assign w_take  = start && !busy;

    assign w_ctl.ins   = w_take && (i_action == spq_pkg::ACT_INSERT) && !w_full;
    assign w_ctl.rem   = w_take && (i_action == spq_pkg::ACT_REMOVE) && !w_empty;
    assign w_ctl.prio  = i_item_priority;
    assign w_ctl.value = i_item_value;

    assign w_placed[0] = 1'b0;

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        spq_pkg::t_entry w_left;
        spq_pkg::t_entry w_right;

        if (gi == 0) begin : g_head
            assign w_left = '0;
        end else begin : g_body
            assign w_left = w_ent[gi-1];
        end

        // Past the tail an empty slot shifts in on remove.
        if (gi == CAPACITY - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_mid
            assign w_right = w_ent[gi+1];
        end

        spq_cell #(
            .IS_HEAD (gi == 0)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_placed (w_placed[gi]),
            .i_left   (w_left),
            .i_right  (w_right),
            .o_placed (w_placed[gi+1]),
            .o_entry  (w_ent[gi])
        );
    end

    // Build the result for the item taken this cycle.
    always_comb begin
        n_value  = spq_pkg::NO_VALUE;
        n_status = spq_pkg::ST_DONE;
        if (i_action == spq_pkg::ACT_INSERT) begin
            if (w_full) begin
                n_status = spq_pkg::ST_FULL;
            end
        end else begin
            if (w_empty) begin
                n_status = spq_pkg::ST_EMPTY;
            end else begin
                n_value = w_ent[0].value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_run    <= 1'b1;
            r_strobe <= w_take;
        end
        if (w_take) begin
            r_value  <= n_value;
            r_status <= n_status;
        end
    end

    assign busy            = !r_run;
    assign o_strobe        = r_strobe;
    assign o_removed_value = r_value;
    assign o_status        = r_status;

endmodule

// ===== rtl/spq_cell.sv =====
// One slot of the sorted queue chain: holds one entry, compares it with the
// broadcast priority and shifts to or from its neighbors. Depends on spq_pkg.
module spq_cell #(
    parameter bit IS_HEAD = 1'b0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  spq_pkg::t_ctl   i_ctl,
    input  logic            i_placed,
    input  spq_pkg::t_entry i_left,
    input  spq_pkg::t_entry i_right,
    output logic            o_placed,
    output spq_pkg::t_entry o_entry
);

    logic                              r_vld;
    logic signed [spq_pkg::PRIO_W-1:0]  r_prio;
    logic signed [spq_pkg::VALUE_W-1:0] r_value;
    logic                              n_vld;
    logic signed [spq_pkg::PRIO_W-1:0]  n_prio;
    logic signed [spq_pkg::VALUE_W-1:0] n_value;
    logic                              w_here;

    // The head lets a new pair go ahead of ties; later slots keep it behind.
    always_comb begin
        if (IS_HEAD) begin
            w_here = !r_vld || (i_ctl.prio >= r_prio);
        end else begin
            w_here = !r_vld || (i_ctl.prio > r_prio);
        end
    end

    assign o_placed = i_placed | w_here;

    always_comb begin
        n_vld   = r_vld;
        n_prio  = r_prio;
        n_value = r_value;
        if (i_ctl.ins) begin
            if (i_placed) begin
                n_vld   = i_left.vld;
                n_prio  = i_left.prio;
                n_value = i_left.value;
            end else if (w_here) begin
                n_vld   = 1'b1;
                n_prio  = i_ctl.prio;
                n_value = i_ctl.value;
            end
        end else if (i_ctl.rem) begin
            n_vld   = i_right.vld;
            n_prio  = i_right.prio;
            n_value = i_right.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        r_prio  <= n_prio;
        r_value <= n_value;
    end

    assign o_entry.vld   = r_vld;
    assign o_entry.prio  = r_prio;
    assign o_entry.value = r_value;

endmodule

// ===== rtl/spq_checker.sv =====
// Port-level checks for sorted_priority_queue_unit, attached by bind.
// Depends on spq_pkg.
module spq_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               i_action,
    input logic                               o_strobe,
    input logic signed [spq_pkg::VALUE_W-1:0] o_removed_value,
    input logic [1:0]                         o_status
);

    // One result in the cycle after each taken item.
    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_strobe)
        else $error("result missing after taken item");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_strobe)
        else $error("result without a taken item");

    // Failed operations return all ones.
    a_fail_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != spq_pkg::ST_DONE) |->
            (o_removed_value == spq_pkg::NO_VALUE))
        else $error("failed item returned a value");

    // Empty only answers a remove, full only answers an insert.
    a_status_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=>
            ((o_status == spq_pkg::ST_EMPTY && $past(i_action) == spq_pkg::ACT_REMOVE) ||
             (o_status == spq_pkg::ST_FULL && $past(i_action) == spq_pkg::ACT_INSERT) ||
             (o_status == spq_pkg::ST_DONE)))
        else $error("status does not match the action");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_action        (i_action),
    .o_strobe        (o_strobe),
    .o_removed_value (o_removed_value),
    .o_status        (o_status)
);

// ===== test/testbench.sv =====
// Self-checking bench for sorted_priority_queue_unit: a directed table, then random
// fill/drain bursts, scored against a behavioral copy of the queue or hand-typed results.
// Depends on spq_pkg and the RTL of sorted_priority_queue_unit only.
`timescale 1ns / 1ps

module testbench;

    localparam int CAP        = spq_pkg::CAPACITY_DEF;
    localparam int VW         = spq_pkg::VALUE_W;
    localparam int PW         = spq_pkg::PRIO_W;
    localparam int PLAN_ROWS  = 24;
    localparam int CYCLE_MAX  = 100000;
    localparam int PHASE_ITEMS = 213;

    // Short local names for the package codes, to keep the table readable.
    localparam logic                 INS    = spq_pkg::ACT_INSERT;
    localparam logic                 REM    = spq_pkg::ACT_REMOVE;
    localparam logic signed [VW-1:0] NONE   = spq_pkg::NO_VALUE;
    localparam spq_pkg::t_status     S_DONE = spq_pkg::ST_DONE;
    localparam spq_pkg::t_status     S_EMPT = spq_pkg::ST_EMPTY;
    localparam spq_pkg::t_status     S_FULL = spq_pkg::ST_FULL;

    // One result of the queue: the value a remove returns and the status code.
    typedef struct packed {
        logic signed [VW-1:0] value;
        spq_pkg::t_status     status;
    } t_outcome;

    // One row of stimulus; 'given' marks rows whose result is typed in by hand.
    typedef struct packed {
        logic                 act;
        logic signed [VW-1:0] value;
        logic signed [PW-1:0] prio;
        logic                 given;
        logic signed [VW-1:0] want_value;
        spq_pkg::t_status     want_status;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_action = INS;
    logic signed [VW-1:0] i_item_value = '0;
    logic signed [PW-1:0] i_item_priority = '0;
    logic                 o_strobe;
    logic signed [VW-1:0] o_removed_value;
    logic [1:0]           o_status;

    // Hand-typed expectation travels with the item, registered like the inputs.
    logic                 row_given = 1'b0;
    logic signed [VW-1:0] row_value = '0;
    spq_pkg::t_status     row_status = S_DONE;

    // Behavioral copy of the queue contents, front at index 0.
    logic signed [VW-1:0] held_value [CAP];
    logic signed [PW-1:0] held_prio [CAP];
    int                   held_count = 0;

    t_outcome owed_results [$];
    t_row     plan [PLAN_ROWS];

    int cycle_count  = 0;
    int errors       = 0;
    int n_items      = 0;
    int n_inserts    = 0;
    int n_removes    = 0;
    int n_full       = 0;
    int n_empty      = 0;
    int n_results    = 0;
    int peak_count   = 0;

    sorted_priority_queue_unit #(
        .CAPACITY(CAP)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_item_value   (i_item_value),
        .i_item_priority(i_item_priority),
        .o_strobe       (o_strobe),
        .o_removed_value(o_removed_value),
        .o_status       (o_status)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Apply one item to the queue copy and return what the block must report.
    // An insert lands behind every entry of equal or higher priority, unless it
    // ties or beats the front, in which case it jumps to the front.
    function automatic t_outcome queue_step(input logic act,
                                            input logic signed [VW-1:0] value,
                                            input logic signed [PW-1:0] prio);
        t_outcome res;
        int       pos;
        res.value  = NONE;
        res.status = S_DONE;
        if (act == INS) begin
            if (held_count >= CAP) begin
                res.status = S_FULL;
            end else begin
                pos = 0;
                if (held_count != 0 && prio < held_prio[0]) begin
                    while (pos < held_count && held_prio[pos] >= prio) pos++;
                end
                for (int i = held_count; i > pos; i--) begin
                    held_value[i] = held_value[i-1];
                    held_prio[i]  = held_prio[i-1];
                end
                held_value[pos] = value;
                held_prio[pos]  = prio;
                held_count++;
            end
        end else begin
            if (held_count == 0) begin
                res.status = S_EMPT;
            end else begin
                res.value = held_value[0];
                for (int i = 1; i < held_count; i++) begin
                    held_value[i-1] = held_value[i];
                    held_prio[i-1]  = held_prio[i];
                end
                held_count--;
            end
        end
        return res;
    endfunction

    // Scoreboard. Everything here reads pre-edge values, so the order of processes
    // at the edge does not matter. Check the returned result first, then record
    // the item taken at this edge.
    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome pred;
        if (o_strobe === 1'b1) begin
            n_results++;
            if (owed_results.size() == 0) begin
                errors++;
                $display("%0t: expected no result, got value %0d status %0d",
                         $time, o_removed_value, o_status);
            end else begin
                want = owed_results.pop_front();
                if (o_removed_value !== want.value) begin
                    errors++;
                    $display("%0t: removed_value expected %0d (%h) got %0d (%h)",
                             $time, want.value, want.value,
                             o_removed_value, o_removed_value);
                end
                if (o_status !== want.status) begin
                    errors++;
                    $display("%0t: status expected %0d got %0d",
                             $time, want.status, o_status);
                end
            end
        end
        if (i_rst_n === 1'b1 && start === 1'b1 && busy === 1'b0) begin
            // Always advance the copy; a hand-typed row only overrides the answer.
            pred = queue_step(i_action, i_item_value, i_item_priority);
            if (row_given) begin
                pred.value  = row_value;
                pred.status = row_status;
            end
            owed_results.push_back(pred);
            n_items++;
            if (i_action == INS) n_inserts++;
            else n_removes++;
            if (pred.status == S_FULL) n_full++;
            if (pred.status == S_EMPT) n_empty++;
            if (held_count > peak_count) peak_count = held_count;
        end
    end

    // Present one item and hold it until the block takes it. Call right after a
    // rising edge; start stays high on return so back-to-back items never dip.
    task automatic issue_item(input t_row row);
        start           <= 1'b1;
        i_action        <= row.act;
        i_item_value    <= row.value;
        i_item_priority <= row.prio;
        row_given       <= row.given;
        row_value       <= row.want_value;
        row_status      <= row.want_status;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Drop start and wait until every owed result has come back.
    task automatic drain_results();
        start <= 1'b0;
        do @(negedge i_clk); while (owed_results.size() != 0);
        @(posedge i_clk);
    endtask

    // Simple watchdog: no correct run comes anywhere near this many cycles.
    initial begin
        wait (cycle_count >= CYCLE_MAX);
        $display("%0t: timeout with %0d results still owed", $time, owed_results.size());
        $display("Verification failed");
        $finish;
    end

    initial begin
        t_row row;
        int   idle_pct [4];
        int   burst_left;
        int   ins_pct;

        // Directed table. Inserts that succeed always answer all ones / done, and
        // the empty and full cases are fixed, so those are typed in; removes are
        // left to the predictor.
        plan[0]  = '{REM, 32'sh1234_5678, 16'sh7FFF, 1'b1, NONE, S_EMPT};
        plan[1]  = '{INS, 32'sh7FFF_FFFF, 16'sh7FFF, 1'b1, NONE, S_DONE};
        plan[2]  = '{INS, 32'sh8000_0000, 16'sh8000, 1'b1, NONE, S_DONE};
        plan[3]  = '{INS, 32'sd5,         16'sd0,    1'b1, NONE, S_DONE};
        plan[4]  = '{INS, 32'sd6,         16'sd0,    1'b1, NONE, S_DONE};
        // ties with the front priority: must go ahead of the old front
        plan[5]  = '{INS, 32'sd7,         16'sh7FFF, 1'b1, NONE, S_DONE};
        plan[6]  = '{REM, 32'shFFFF_FFFF, 16'shFFFF, 1'b0, NONE, S_DONE};
        plan[7]  = '{REM, 32'sh0000_0000, 16'sh0000, 1'b0, NONE, S_DONE};
        // fill up to capacity with ties, extremes and mixed bit patterns
        plan[8]  = '{INS, 32'sh5555_5555, 16'sh5555, 1'b1, NONE, S_DONE};
        plan[9]  = '{INS, 32'shAAAA_AAAA, 16'shAAAA, 1'b1, NONE, S_DONE};
        plan[10] = '{INS, 32'shFFFF_FFFF, 16'sd0,    1'b1, NONE, S_DONE};
        plan[11] = '{INS, 32'sd1,         -16'sd1,   1'b1, NONE, S_DONE};
        plan[12] = '{INS, 32'sd2,         16'sd1,    1'b1, NONE, S_DONE};
        plan[13] = '{INS, 32'sd3,         16'sh8000, 1'b1, NONE, S_DONE};
        plan[14] = '{INS, 32'sd4,         16'sh7FFF, 1'b1, NONE, S_DONE};
        plan[15] = '{INS, 32'sh0F0F_0F0F, 16'sd1,    1'b1, NONE, S_DONE};
        plan[16] = '{INS, 32'shF0F0_F0F0, 16'sh7FFE, 1'b1, NONE, S_DONE};
        plan[17] = '{INS, 32'sh0000_0000, 16'sh8001, 1'b1, NONE, S_DONE};
        plan[18] = '{INS, 32'sh3333_3333, 16'sd0,    1'b1, NONE, S_DONE};
        plan[19] = '{INS, 32'shCCCC_CCCC, 16'sh00FF, 1'b1, NONE, S_DONE};
        plan[20] = '{INS, 32'sh8000_0001, 16'shFF00, 1'b1, NONE, S_DONE};
        // queue is full now: the pair is dropped
        plan[21] = '{INS, 32'sh7654_3210, 16'sh7FFF, 1'b1, NONE, S_FULL};
        plan[22] = '{REM, 32'shFFFF_FFFF, 16'shFFFF, 1'b0, NONE, S_DONE};
        plan[23] = '{REM, 32'sh8000_0000, 16'sh8000, 1'b0, NONE, S_DONE};

        // Percent of cycles the sender sits idle, per random phase. The result
        // side cannot be held off, so only the sender ever idles.
        idle_pct[0] = 0;
        idle_pct[1] = 77;
        idle_pct[2] = 0;
        idle_pct[3] = 25;

        // Hold reset low at the start, then release it for good.
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < PLAN_ROWS; r++) issue_item(plan[r]);
        drain_results();

        // Random part: bursts biased toward filling or draining, so the queue
        // swings between empty and full; priorities lean on a few values to
        // force ties, with the extremes and fully random values mixed in.
        burst_left = 0;
        ins_pct    = 50;
        for (int ph = 0; ph < 4; ph++) begin
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(40, 4);
                    case ($urandom_range(2))
                        0:       ins_pct = 90;
                        1:       ins_pct = 50;
                        default: ins_pct = 15;
                    endcase
                end
                burst_left--;

                row.act   = ($urandom_range(99) < ins_pct) ? INS : REM;
                row.given = 1'b0;
                row.want_value  = NONE;
                row.want_status = S_DONE;
                case ($urandom_range(9))
                    0:       row.value = 32'sh7FFF_FFFF;
                    1:       row.value = 32'sh8000_0000;
                    2:       row.value = NONE;
                    default: row.value = $urandom;
                endcase
                case ($urandom_range(9))
                    0:          row.prio = 16'sh7FFF;
                    1:          row.prio = 16'sh8000;
                    2, 3, 4, 5: row.prio = 16'($urandom_range(4)) - 16'sd2;
                    default:    row.prio = 16'($urandom);
                endcase

                // idle a random number of cycles before the item, per the phase
                while ($urandom_range(99) < idle_pct[ph]) begin
                    start <= 1'b0;
                    @(posedge i_clk);
                end
                issue_item(row);
            end
            // pause the sender until the block has answered everything
            drain_results();
        end

        // Nothing owed any more; wait so that a stray strobe has time to show up.
        repeat (4) @(posedge i_clk);

        $display("Ran %0d items: %0d inserts, %0d removes, %0d results seen.",
                 n_items, n_inserts, n_removes, n_results);
        $display("Queue depth peaked at %0d; %0d inserts dropped full, %0d removes on empty.",
                 peak_count, n_full, n_empty);
        if (errors == 0 && owed_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d results still owed", errors, owed_results.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule
